/* hdl/rso_pkg.sv */
`default_nettype none

package rso_pkg;

  // Operation codes carried by the cmd field.
  typedef enum logic [1:0] {
    CMD_SUB   = 2'd0,
    CMD_UNI   = 2'd1,
    CMD_ISECT = 2'd2,
    CMD_BOUND = 2'd3
  } cmd_t;

  // Default coordinate width for the internal edge arithmetic.
  localparam int COORD_BITS_DEF = 16;

  // Default number of classified items held between front and back.
  localparam int QUEUE_DEPTH_DEF = 2;

  // At most four result rectangles come out of one item.
  localparam int MAX_RESULTS = 4;
  localparam int IDX_W       = $clog2(MAX_RESULTS);

  // Width used to sign- or zero-extend before cutting to a target width.
  localparam int EXT_W = 48;

  // Widths of the fixed port fields.
  localparam int POS_W  = 16;
  localparam int SIZE_W = 15;
  localparam int OSZ_W  = 16;

endpackage

`default_nettype wire

/* hdl/rect_set_op_unit.sv */
// An accepted item passes the first-stage edge registers, the queue and the output register
// before its first result shows on the outputs.
// Throughput: one result per cycle from the back emitter while out_stall is low; an item
// gives one to four results, and the queue ahead of the emitter lets the front go on.
// Reset: synchronous active-low rst_n empties the pipeline, queue and output register;
// no clearing pass is needed.
`default_nettype none

module rect_set_op_unit #(
  parameter int COORD_BITS  = rso_pkg::COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = rso_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       in_cmd,
  input  wire logic signed [rso_pkg::POS_W-1:0] in_a_left,
  input  wire logic signed [rso_pkg::POS_W-1:0] in_a_top,
  input  wire logic [rso_pkg::SIZE_W-1:0]       in_a_wide,
  input  wire logic [rso_pkg::SIZE_W-1:0]       in_a_tall,
  input  wire logic signed [rso_pkg::POS_W-1:0] in_b_left,
  input  wire logic signed [rso_pkg::POS_W-1:0] in_b_top,
  input  wire logic [rso_pkg::SIZE_W-1:0]       in_b_wide,
  input  wire logic [rso_pkg::SIZE_W-1:0]       in_b_tall,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [rso_pkg::POS_W-1:0]      out_left,
  output logic signed [rso_pkg::POS_W-1:0]      out_top,
  output logic [rso_pkg::OSZ_W-1:0]             out_wide,
  output logic [rso_pkg::OSZ_W-1:0]             out_tall,
  output logic                                  out_is_empty,
  output logic                                  out_is_last
);

  localparam int ENTRY_W = rso_pkg::MAX_RESULTS * 4 * COORD_BITS + rso_pkg::IDX_W + 1;

  logic               q_push, q_full, q_pop, q_vld;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;

  // Front: edge arithmetic and classification into a result list.
  rso_front #(
    .C       (COORD_BITS),
    .ENTRY_W (ENTRY_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .in_a_left (in_a_left),
    .in_a_top  (in_a_top),
    .in_a_wide (in_a_wide),
    .in_a_tall (in_a_tall),
    .in_b_left (in_b_left),
    .in_b_top  (in_b_top),
    .in_b_wide (in_b_wide),
    .in_b_tall (in_b_tall),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  // Short queue of classified items.
  rso_queue #(
    .W     (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .head_vld  (q_vld),
    .head_data (q_rdata)
  );

  // Back: one result rectangle per cycle while the output is not stalled.
  rso_back #(
    .C       (COORD_BITS),
    .ENTRY_W (ENTRY_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_vld        (q_vld),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_left     (out_left),
    .out_top      (out_top),
    .out_wide     (out_wide),
    .out_tall     (out_tall),
    .out_is_empty (out_is_empty),
    .out_is_last  (out_is_last)
  );

endmodule

`default_nettype wire

/* hdl/rso_queue.sv */
`default_nettype none

module rso_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic              head_vld,
  output logic [W-1:0]      head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  logic [W-1:0]  store_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == DEPTH_CNT);
  assign head_vld  = (cnt_r != '0);
  assign head_data = store_r[rd_ptr_r];

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  // The fill count never passes the depth, and nothing leaves an empty queue.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_CNT) else $error("queue fill count beyond depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0) else $error("queue popped while empty");

endmodule

`default_nettype wire

/* hdl/rso_front.sv */
`default_nettype none

module rso_front #(
  parameter int C       = rso_pkg::COORD_BITS_DEF,
  parameter int ENTRY_W = rso_pkg::MAX_RESULTS * 4 * C + rso_pkg::IDX_W + 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       in_cmd,
  input  wire logic signed [rso_pkg::POS_W-1:0] in_a_left,
  input  wire logic signed [rso_pkg::POS_W-1:0] in_a_top,
  input  wire logic [rso_pkg::SIZE_W-1:0]       in_a_wide,
  input  wire logic [rso_pkg::SIZE_W-1:0]       in_a_tall,
  input  wire logic signed [rso_pkg::POS_W-1:0] in_b_left,
  input  wire logic signed [rso_pkg::POS_W-1:0] in_b_top,
  input  wire logic [rso_pkg::SIZE_W-1:0]       in_b_wide,
  input  wire logic [rso_pkg::SIZE_W-1:0]       in_b_tall,
  output logic                                  q_push,
  output logic [ENTRY_W-1:0]                    q_data,
  input  wire logic                             q_full
);

  localparam int EW    = rso_pkg::EXT_W;
  localparam int PW    = rso_pkg::POS_W;
  localparam int SW    = rso_pkg::SIZE_W;
  localparam int MAXR  = rso_pkg::MAX_RESULTS;
  localparam int IW    = rso_pkg::IDX_W;
  localparam int NCAND = MAXR + 1;
  localparam logic [C-1:0] ONE = {{(C-1){1'b0}}, 1'b1};

  typedef struct packed {
    logic [C-1:0] l;
    logic [C-1:0] t;
    logic [C-1:0] r;
    logic [C-1:0] b;
  } box_t;

  typedef struct packed {
    box_t [MAXR-1:0] bx;
    logic [IW-1:0]   last;
    logic            emp;
  } entry_t;

  // Bring a port coordinate to the internal width.
  function automatic logic [C-1:0] pos_in(input logic [PW-1:0] v);
    logic [EW-1:0] x;
    x = {{(EW-PW){v[PW-1]}}, v};
    return x[C-1:0];
  endfunction

  function automatic logic [C-1:0] size_in(input logic [SW-1:0] v);
    logic [EW-1:0] x;
    x = {{(EW-SW){1'b0}}, v};
    return x[C-1:0];
  endfunction

  function automatic box_t mk(input logic [C-1:0] l, input logic [C-1:0] t,
                              input logic [C-1:0] r, input logic [C-1:0] b);
    box_t x;
    x.l = l;
    x.t = t;
    x.r = r;
    x.b = b;
    return x;
  endfunction

  // First stage: edges of both rectangles.
  logic                s1_vld_r;
  rso_pkg::cmd_t       s1_cmd_r;
  logic signed [C-1:0] al_r, at_r, ar_r, ab_r;
  logic signed [C-1:0] bl_r, bt_r, br_r, bb_r;

  assign in_stall = s1_vld_r && q_full;
  assign q_push   = s1_vld_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cmd_r <= rso_pkg::cmd_t'(in_cmd);
      al_r     <= pos_in(in_a_left);
      at_r     <= pos_in(in_a_top);
      ar_r     <= pos_in(in_a_left) + size_in(in_a_wide) - ONE;
      ab_r     <= pos_in(in_a_top) + size_in(in_a_tall) - ONE;
      bl_r     <= pos_in(in_b_left);
      bt_r     <= pos_in(in_b_top);
      br_r     <= pos_in(in_b_left) + size_in(in_b_wide) - ONE;
      bb_r     <= pos_in(in_b_top) + size_in(in_b_tall) - ONE;
    end
  end

  // Second stage: overlap tests and the side-by-side edge relations.
  logic         apart;
  logic         sl, st, sr, sb;
  logic         ol, ot, orr, ob;
  logic [2:0]   out_cnt;
  logic [C-1:0] mt_sub, mb_sub, mt_uni, mb_uni;
  box_t         box_a, box_b;

  always_comb begin
    apart   = (al_r > br_r) || (ar_r < bl_r) || (at_r > bb_r) || (ab_r < bt_r);
    sl      = bl_r > al_r;
    st      = bt_r > at_r;
    sr      = br_r < ar_r;
    sb      = bb_r < ab_r;
    ol      = bl_r < al_r;
    ot      = bt_r < at_r;
    orr     = br_r > ar_r;
    ob      = bb_r > ab_r;
    out_cnt = {2'b00, ol} + {2'b00, ot} + {2'b00, orr} + {2'b00, ob};
    mt_sub  = st ? bt_r : at_r;
    mb_sub  = sb ? bb_r : ab_r;
    mt_uni  = (at_r > bt_r) ? at_r : bt_r;
    mb_uni  = (bb_r < ab_r) ? bb_r : ab_r;
    box_a   = mk(al_r, at_r, ar_r, ab_r);
    box_b   = mk(bl_r, bt_r, br_r, bb_r);
  end

  // Candidate rectangles in answer order, each with an enable.
  box_t             cand [NCAND];
  logic [NCAND-1:0] cand_en;

  always_comb begin
    for (int i = 0; i < NCAND; i++) begin
      cand[i] = box_a;
    end
    cand_en = '0;
    unique case (s1_cmd_r)
      rso_pkg::CMD_SUB: begin
        if (apart) begin
          cand[0]    = box_a;
          cand_en[0] = 1'b1;
        end else begin
          cand[0]    = mk(al_r, mt_sub, bl_r - ONE, mb_sub);
          cand[1]    = mk(al_r, at_r, ar_r, bt_r - ONE);
          cand[2]    = mk(br_r + ONE, mt_sub, ar_r, mb_sub);
          cand[3]    = mk(al_r, bb_r + ONE, ar_r, ab_r);
          cand_en[0] = sl;
          cand_en[1] = st;
          cand_en[2] = sr;
          cand_en[3] = sb;
        end
      end
      rso_pkg::CMD_UNI: begin
        if (apart) begin
          cand[0]    = box_b;
          cand[1]    = box_a;
          cand_en[1:0] = 2'b11;
        end else if (out_cnt <= 3'd2) begin
          cand[0]    = box_a;
          cand[1]    = mk(bl_r, mt_uni, al_r - ONE, mb_uni);
          cand[2]    = mk(bl_r, bt_r, br_r, at_r - ONE);
          cand[3]    = mk(ar_r + ONE, mt_uni, br_r, mb_uni);
          cand[4]    = mk(bl_r, ab_r + ONE, br_r, bb_r);
          cand_en[0] = 1'b1;
          cand_en[1] = ol;
          cand_en[2] = ot;
          cand_en[3] = orr;
          cand_en[4] = ob;
        end else begin
          cand[0]    = box_b;
          cand_en[0] = 1'b1;
          // With three sides out, A may still show on the fourth side.
          if (out_cnt == 3'd3) begin
            priority if (!ol) begin
              cand[1]    = mk(al_r, at_r, bl_r - ONE, ab_r);
              cand_en[1] = sl;
            end else if (!ot) begin
              cand[1]    = mk(al_r, at_r, ar_r, bt_r - ONE);
              cand_en[1] = st;
            end else if (!orr) begin
              cand[1]    = mk(br_r + ONE, at_r, ar_r, ab_r);
              cand_en[1] = sr;
            end else begin
              cand[1]    = mk(al_r, bb_r + ONE, ar_r, ab_r);
              cand_en[1] = sb;
            end
          end
        end
      end
      rso_pkg::CMD_ISECT: begin
        cand[0] = mk((al_r > bl_r) ? al_r : bl_r, mt_uni,
                     (ar_r < br_r) ? ar_r : br_r, mb_uni);
        cand_en[0] = !apart;
      end
      rso_pkg::CMD_BOUND: begin
        cand[0] = mk((al_r < bl_r) ? al_r : bl_r, (at_r < bt_r) ? at_r : bt_r,
                     (ar_r > br_r) ? ar_r : br_r, (ab_r > bb_r) ? ab_r : bb_r);
        cand_en[0] = 1'b1;
      end
      default: begin
        cand_en = '0;
      end
    endcase
  end

  // Pack the enabled candidates into consecutive result slots.
  entry_t      ent;
  logic [IW:0] n;

  always_comb begin
    ent = '0;
    n   = '0;
    for (int i = 0; i < NCAND; i++) begin
      if (cand_en[i] && (n < (IW + 1)'(MAXR))) begin
        ent.bx[n[IW-1:0]] = cand[i];
        n = n + 1'b1;
      end
    end
    if (n == '0) begin
      ent.emp  = 1'b1;
      ent.last = '0;
    end else begin
      ent.emp  = 1'b0;
      ent.last = IW'(n - 1'b1);
    end
  end

  assign q_data = ent;

  // An empty answer is always a single result; a bounding box is never empty.
  a_empty_single: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && ent.emp |-> ent.last == '0) else $error("empty answer with several results");
  a_bound_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && s1_cmd_r == rso_pkg::CMD_BOUND |-> !ent.emp && ent.last == '0)
    else $error("bounding box gave no single rectangle");

endmodule

`default_nettype wire

/* hdl/rso_back.sv */
`default_nettype none

module rso_back #(
  parameter int C       = rso_pkg::COORD_BITS_DEF,
  parameter int ENTRY_W = rso_pkg::MAX_RESULTS * 4 * C + rso_pkg::IDX_W + 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_vld,
  input  wire logic [ENTRY_W-1:0]         q_data,
  output logic                            q_pop,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [rso_pkg::POS_W-1:0] out_left,
  output logic signed [rso_pkg::POS_W-1:0] out_top,
  output logic [rso_pkg::OSZ_W-1:0]       out_wide,
  output logic [rso_pkg::OSZ_W-1:0]       out_tall,
  output logic                            out_is_empty,
  output logic                            out_is_last
);

  localparam int EW   = rso_pkg::EXT_W;
  localparam int PW   = rso_pkg::POS_W;
  localparam int OW   = rso_pkg::OSZ_W;
  localparam int MAXR = rso_pkg::MAX_RESULTS;
  localparam int IW   = rso_pkg::IDX_W;
  localparam logic [C-1:0] ONE = {{(C-1){1'b0}}, 1'b1};

  typedef struct packed {
    logic [C-1:0] l;
    logic [C-1:0] t;
    logic [C-1:0] r;
    logic [C-1:0] b;
  } box_t;

  typedef struct packed {
    box_t [MAXR-1:0] bx;
    logic [IW-1:0]   last;
    logic            emp;
  } entry_t;

  // Cut an internal value to a 16-bit port, sign-extending when narrower.
  function automatic logic [PW-1:0] to_port(input logic [C-1:0] v);
    logic [EW-1:0] x;
    x = {{(EW-C){v[C-1]}}, v};
    return x[PW-1:0];
  endfunction

  entry_t        head;
  box_t          sel;
  logic [C-1:0]  w_int, h_int;
  logic          is_last;
  logic          load;
  logic [IW-1:0] idx_r;

  logic              out_valid_r;
  logic [PW-1:0]     out_left_r, out_top_r;
  logic [OW-1:0]     out_wide_r, out_tall_r;
  logic              out_is_empty_r, out_is_last_r;

  // Pick the current result of the head item and size it.
  always_comb begin
    head    = entry_t'(q_data);
    sel     = head.bx[idx_r];
    w_int   = sel.r - sel.l + ONE;
    h_int   = sel.b - sel.t + ONE;
    is_last = (idx_r == head.last);
    load    = q_vld && (!out_valid_r || !out_stall);
    q_pop   = load && is_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      idx_r       <= is_last ? '0 : idx_r + 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register; an empty answer shows all-zero geometry.
  always_ff @(posedge clk) begin
    if (load) begin
      out_is_empty_r <= head.emp;
      out_is_last_r  <= is_last;
      if (head.emp) begin
        out_left_r <= '0;
        out_top_r  <= '0;
        out_wide_r <= '0;
        out_tall_r <= '0;
      end else begin
        out_left_r <= to_port(sel.l);
        out_top_r  <= to_port(sel.t);
        out_wide_r <= OW'(to_port(w_int));
        out_tall_r <= OW'(to_port(h_int));
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_left     = out_left_r;
  assign out_top      = out_top_r;
  assign out_wide     = out_wide_r;
  assign out_tall     = out_tall_r;
  assign out_is_empty = out_is_empty_r;
  assign out_is_last  = out_is_last_r;

  // An empty result closes its item and carries no geometry.
  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_is_empty_r |-> out_is_last_r && out_wide_r == '0 &&
    out_tall_r == '0) else $error("empty result malformed");
  // The result index stays within the head item's result count.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_vld |-> idx_r <= head.last) else $error("result index past last result");

endmodule

`default_nettype wire

/* tb/rect_result_checker.sv */
`default_nettype none

module rect_result_checker (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic                         in_stall,
  input  wire logic [1:0]                   in_cmd,
  input  wire logic [rso_pkg::POS_W-1:0]    in_a_left,
  input  wire logic [rso_pkg::POS_W-1:0]    in_a_top,
  input  wire logic [rso_pkg::SIZE_W-1:0]   in_a_wide,
  input  wire logic [rso_pkg::SIZE_W-1:0]   in_a_tall,
  input  wire logic [rso_pkg::POS_W-1:0]    in_b_left,
  input  wire logic [rso_pkg::POS_W-1:0]    in_b_top,
  input  wire logic [rso_pkg::SIZE_W-1:0]   in_b_wide,
  input  wire logic [rso_pkg::SIZE_W-1:0]   in_b_tall,
  input  wire logic                         out_valid,
  input  wire logic                         out_stall,
  input  wire logic [rso_pkg::POS_W-1:0]    out_left,
  input  wire logic [rso_pkg::POS_W-1:0]    out_top,
  input  wire logic [rso_pkg::OSZ_W-1:0]    out_wide,
  input  wire logic [rso_pkg::OSZ_W-1:0]    out_tall,
  input  wire logic                         out_is_empty,
  input  wire logic                         out_is_last,
  output int                                rect_errors,
  output int                                rects_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [rso_pkg::COORD_BITS_DEF-1:0] coord_t;
  typedef logic [rso_pkg::POS_W-1:0]  pos_t;
  typedef logic [rso_pkg::SIZE_W-1:0] dim_t;
  typedef logic [rso_pkg::OSZ_W-1:0]  osz_t;

  // A rectangle held as its four inclusive edges.
  typedef struct {
    coord_t l;
    coord_t t;
    coord_t r;
    coord_t b;
  } edges_t;

  // One result item as it should leave the block.
  typedef struct {
    pos_t left;
    pos_t top;
    osz_t wide;
    osz_t tall;
    logic empty;
    logic last;
  } rect_item_t;

  rect_item_t want_rects[$];

  function automatic coord_t cmax(coord_t x, coord_t y);
    return (x > y) ? x : y;
  endfunction

  function automatic coord_t cmin(coord_t x, coord_t y);
    return (x < y) ? x : y;
  endfunction

  function automatic edges_t span(coord_t l, coord_t t, coord_t r, coord_t b);
    edges_t e;
    e.l = l;
    e.t = t;
    e.r = r;
    e.b = b;
    return e;
  endfunction

  // Origin and size to edges; a size of zero puts the far edge one before the origin.
  function automatic edges_t to_edges(pos_t left, pos_t top, dim_t wide, dim_t tall);
    edges_t e;
    e.l = coord_t'(left);
    e.t = coord_t'(top);
    e.r = e.l + coord_t'({1'b0, wide}) - coord_t'(1);
    e.b = e.t + coord_t'({1'b0, tall}) - coord_t'(1);
    return e;
  endfunction

  // Queue one rectangle, sizes worked out with wrap-around.
  function automatic void emit_rect(edges_t e);
    rect_item_t it;
    it.left  = e.l;
    it.top   = e.t;
    it.wide  = osz_t'(coord_t'(e.r - e.l + coord_t'(1)));
    it.tall  = osz_t'(coord_t'(e.b - e.t + coord_t'(1)));
    it.empty = 1'b0;
    it.last  = 1'b0;
    want_rects.push_back(it);
  endfunction

  function automatic void emit_empty();
    rect_item_t it;
    it.left  = '0;
    it.top   = '0;
    it.wide  = '0;
    it.tall  = '0;
    it.empty = 1'b1;
    it.last  = 1'b0;
    want_rects.push_back(it);
  endfunction

  // Work out every result rectangle of one item and mark the final one.
  function automatic void predict_set_op(rso_pkg::cmd_t op, edges_t a, edges_t b);
    logic       apart;
    logic       sl, st, sr, sb;
    logic       ol, ot, orr, ob;
    int         n_sides;
    coord_t     mt, mb;
    rect_item_t tail;
    apart = (a.l > b.r) || (a.r < b.l) || (a.t > b.b) || (a.b < b.t);
    case (op)
      rso_pkg::CMD_SUB: begin
        if (apart) begin
          emit_rect(a);
        end else begin
          sl = b.l > a.l;
          st = b.t > a.t;
          sr = b.r < a.r;
          sb = b.b < a.b;
          mt = st ? b.t : a.t;
          mb = sb ? b.b : a.b;
          if (sl) emit_rect(span(a.l, mt, b.l - coord_t'(1), mb));
          if (st) emit_rect(span(a.l, a.t, a.r, b.t - coord_t'(1)));
          if (sr) emit_rect(span(b.r + coord_t'(1), mt, a.r, mb));
          if (sb) emit_rect(span(a.l, b.b + coord_t'(1), a.r, a.b));
          // B covers A completely: nothing is left.
          if (!(sl || st || sr || sb)) emit_empty();
        end
      end
      rso_pkg::CMD_UNI: begin
        if (apart) begin
          emit_rect(b);
          emit_rect(a);
        end else begin
          ol = b.l < a.l;
          ot = b.t < a.t;
          orr = b.r > a.r;
          ob = b.b > a.b;
          n_sides = int'(ol) + int'(ot) + int'(orr) + int'(ob);
          if (n_sides <= 2) begin
            mt = cmax(a.t, b.t);
            mb = cmin(b.b, a.b);
            emit_rect(a);
            if (ol) emit_rect(span(b.l, mt, a.l - coord_t'(1), mb));
            if (ot) emit_rect(span(b.l, b.t, b.r, a.t - coord_t'(1)));
            if (orr) emit_rect(span(a.r + coord_t'(1), mt, b.r, mb));
            if (ob) emit_rect(span(b.l, a.b + coord_t'(1), b.r, b.b));
          end else begin
            emit_rect(b);
            // With three sides out, A may still show on the fourth side.
            if (n_sides == 3) begin
              if (!ol) begin
                if (b.l > a.l) emit_rect(span(a.l, a.t, b.l - coord_t'(1), a.b));
              end else if (!ot) begin
                if (b.t > a.t) emit_rect(span(a.l, a.t, a.r, b.t - coord_t'(1)));
              end else if (!orr) begin
                if (b.r < a.r) emit_rect(span(b.r + coord_t'(1), a.t, a.r, a.b));
              end else begin
                if (b.b < a.b) emit_rect(span(a.l, b.b + coord_t'(1), a.r, a.b));
              end
            end
          end
        end
      end
      rso_pkg::CMD_ISECT: begin
        if (apart) begin
          emit_empty();
        end else begin
          emit_rect(span(cmax(a.l, b.l), cmax(a.t, b.t), cmin(a.r, b.r), cmin(a.b, b.b)));
        end
      end
      default: begin
        emit_rect(span(cmin(a.l, b.l), cmin(a.t, b.t), cmax(a.r, b.r), cmax(a.b, b.b)));
      end
    endcase
    tail = want_rects.pop_back();
    tail.last = 1'b1;
    want_rects.push_back(tail);
  endfunction

  // Predict on every accepted input item and compare every accepted result item.
  always @(posedge clk) begin
    rect_item_t got;
    rect_item_t want;
    if (!rst_n) begin
      want_rects.delete();
      rect_errors <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_set_op(rso_pkg::cmd_t'(in_cmd),
                       to_edges(in_a_left, in_a_top, in_a_wide, in_a_tall),
                       to_edges(in_b_left, in_b_top, in_b_wide, in_b_tall));
      end
      if (out_valid && !out_stall) begin
        got.left  = out_left;
        got.top   = out_top;
        got.wide  = out_wide;
        got.tall  = out_tall;
        got.empty = out_is_empty;
        got.last  = out_is_last;
        if (want_rects.size() == 0) begin
          $display("%0t: unexpected result item l=%0d t=%0d w=%0d h=%0d empty=%b last=%b",
                   $time, $signed(got.left), $signed(got.top), got.wide, got.tall,
                   got.empty, got.last);
          rect_errors <= rect_errors + 1;
        end else begin
          want = want_rects.pop_front();
          if (got.left !== want.left || got.top !== want.top || got.wide !== want.wide ||
              got.tall !== want.tall || got.empty !== want.empty ||
              got.last !== want.last) begin
            $display("%0t: mismatch expected l=%0d t=%0d w=%0d h=%0d empty=%b last=%b",
                     $time, $signed(want.left), $signed(want.top), want.wide, want.tall,
                     want.empty, want.last);
            $display("%0t:          actual   l=%0d t=%0d w=%0d h=%0d empty=%b last=%b",
                     $time, $signed(got.left), $signed(got.top), got.wide, got.tall,
                     got.empty, got.last);
            rect_errors <= rect_errors + 1;
          end
        end
      end
    end
    rects_owed <= want_rects.size();
  end

endmodule

`default_nettype wire

/* tb/tb_rect_set_op_unit.sv */
`default_nettype none

module tb_rect_set_op_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM   = 300;
  localparam int IDLE_LIMIT = 5000;

  typedef logic [rso_pkg::POS_W-1:0]  pos_t;
  typedef logic [rso_pkg::SIZE_W-1:0] dim_t;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_stall;
  logic [1:0]                          in_cmd;
  logic signed [rso_pkg::POS_W-1:0]    in_a_left;
  logic signed [rso_pkg::POS_W-1:0]    in_a_top;
  logic [rso_pkg::SIZE_W-1:0]          in_a_wide;
  logic [rso_pkg::SIZE_W-1:0]          in_a_tall;
  logic signed [rso_pkg::POS_W-1:0]    in_b_left;
  logic signed [rso_pkg::POS_W-1:0]    in_b_top;
  logic [rso_pkg::SIZE_W-1:0]          in_b_wide;
  logic [rso_pkg::SIZE_W-1:0]          in_b_tall;
  logic                                out_valid;
  logic                                out_stall;
  logic signed [rso_pkg::POS_W-1:0]    out_left;
  logic signed [rso_pkg::POS_W-1:0]    out_top;
  logic [rso_pkg::OSZ_W-1:0]           out_wide;
  logic [rso_pkg::OSZ_W-1:0]           out_tall;
  logic                                out_is_empty;
  logic                                out_is_last;

  int rect_errors;
  int rects_owed;
  int quiet_cycles;
  bit calm;

  rect_set_op_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_a_left    (in_a_left),
    .in_a_top     (in_a_top),
    .in_a_wide    (in_a_wide),
    .in_a_tall    (in_a_tall),
    .in_b_left    (in_b_left),
    .in_b_top     (in_b_top),
    .in_b_wide    (in_b_wide),
    .in_b_tall    (in_b_tall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_left     (out_left),
    .out_top      (out_top),
    .out_wide     (out_wide),
    .out_tall     (out_tall),
    .out_is_empty (out_is_empty),
    .out_is_last  (out_is_last)
  );

  rect_result_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_a_left    (in_a_left),
    .in_a_top     (in_a_top),
    .in_a_wide    (in_a_wide),
    .in_a_tall    (in_a_tall),
    .in_b_left    (in_b_left),
    .in_b_top     (in_b_top),
    .in_b_wide    (in_b_wide),
    .in_b_tall    (in_b_tall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_left     (out_left),
    .out_top      (out_top),
    .out_wide     (out_wide),
    .out_tall     (out_tall),
    .out_is_empty (out_is_empty),
    .out_is_last  (out_is_last),
    .rect_errors  (rect_errors),
    .rects_owed   (rects_owed)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The result side stalls at random, except during the calm stretch.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = !calm && ($urandom_range(99) < 23);
    end
  end

  // Give up when neither channel has moved an item for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb_rect_set_op_unit: errors");
      $finish;
    end
  end

  function automatic pos_t extreme_coord();
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic dim_t extreme_size();
    case ($urandom_range(2))
      0: return 15'd0;
      1: return 15'd1;
      default: return 15'h7FFF;
    endcase
  endfunction

  // Offer one item, after an optional random gap, and hold it until it is taken.
  task automatic send_pair(input rso_pkg::cmd_t op,
                           input pos_t al, input pos_t at,
                           input dim_t aw, input dim_t ah,
                           input pos_t bl, input pos_t bt,
                           input dim_t bw, input dim_t bh);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_cmd    = op;
    in_a_left = al;
    in_a_top  = at;
    in_a_wide = aw;
    in_a_tall = ah;
    in_b_left = bl;
    in_b_top  = bt;
    in_b_wide = bw;
    in_b_tall = bh;
    in_valid  = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  initial begin
    pos_t          al, at, bl, bt;
    dim_t          aw, ah, bw, bh;
    rso_pkg::cmd_t op;
    int            kind;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_cmd    = rso_pkg::CMD_SUB;
    in_a_left = '0;
    in_a_top  = '0;
    in_a_wide = '0;
    in_a_tall = '0;
    in_b_left = '0;
    in_b_top  = '0;
    in_b_wide = '0;
    in_b_tall = '0;
    calm      = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Subtract: four strips, full cover, disjoint, a single left strip.
    send_pair(rso_pkg::CMD_SUB, 0, 0, 10, 10, 3, 3, 4, 4);
    send_pair(rso_pkg::CMD_SUB, 5, 5, 4, 4, 0, 0, 20, 20);
    send_pair(rso_pkg::CMD_SUB, 0, 0, 10, 10, 100, 100, 5, 5);
    send_pair(rso_pkg::CMD_SUB, 0, 0, 10, 10, 5, -5, 20, 20);
    // Union: disjoint, B inside A, one, two and three sides out.
    send_pair(rso_pkg::CMD_UNI, 0, 0, 10, 10, 100, 100, 5, 5);
    send_pair(rso_pkg::CMD_UNI, 0, 0, 10, 10, 3, 3, 4, 4);
    send_pair(rso_pkg::CMD_UNI, 0, 0, 10, 10, -5, 2, 8, 4);
    send_pair(rso_pkg::CMD_UNI, 0, 0, 10, 10, 5, 5, 10, 10);
    send_pair(rso_pkg::CMD_UNI, 0, 0, 10, 10, 3, -2, 20, 20);
    // Three sides out with A flush on the fourth: the strip has no size; then four sides out.
    send_pair(rso_pkg::CMD_UNI, 0, 0, 10, 10, 0, -2, 20, 20);
    send_pair(rso_pkg::CMD_UNI, 0, 0, 10, 10, -2, -2, 20, 20);
    // Intersect with overlap and without, then a bounding box.
    send_pair(rso_pkg::CMD_ISECT, 0, 0, 10, 10, 5, -3, 10, 8);
    send_pair(rso_pkg::CMD_ISECT, 0, 0, 10, 10, 20, 0, 3, 3);
    send_pair(rso_pkg::CMD_BOUND, -4, 7, 3, 9, 12, -6, 5, 2);
    // Extremes of the coordinates and sizes, with wrapping edges.
    send_pair(rso_pkg::CMD_SUB, 16'h8000, 16'h8000, 15'h7FFF, 15'h7FFF,
              16'h7FFF, 16'h7FFF, 15'h7FFF, 15'h7FFF);
    send_pair(rso_pkg::CMD_UNI, 16'h8000, 16'h8000, 15'h7FFF, 15'h7FFF,
              16'h7FFF, 16'h7FFF, 15'h7FFF, 15'h7FFF);
    send_pair(rso_pkg::CMD_ISECT, 16'h7FFF, 16'h7FFF, 15'h7FFF, 15'h7FFF,
              16'h8000, 16'h8000, 15'h7FFF, 15'h7FFF);
    send_pair(rso_pkg::CMD_BOUND, 16'h8000, 16'h8000, 1, 1, 16'd32000, 16'd32000, 767, 767);
    // Sizes of zero, taken as they stand.
    send_pair(rso_pkg::CMD_SUB, 0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(rso_pkg::CMD_UNI, 0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(rso_pkg::CMD_ISECT, 0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(rso_pkg::CMD_BOUND, 0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(rso_pkg::CMD_SUB, 16'hFFFF, 16'hFFFF, 15'h7FFF, 0, 16'h8000, 16'h7FFF, 0,
              15'h7FFF);

    // Random items: mostly nearby rectangles so that they overlap in every way.
    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i >= 180 && i < 240);
      // Let the block drain completely once before carrying on.
      if (i == 100) begin
        in_valid = 1'b0;
        while (rects_owed != 0) @(negedge clk);
      end
      op   = rso_pkg::cmd_t'($urandom_range(3));
      kind = int'($urandom_range(99));
      if (kind < 65) begin
        al = pos_t'($urandom);
        at = pos_t'($urandom);
        aw = dim_t'($urandom_range(40, 1));
        ah = dim_t'($urandom_range(40, 1));
        bl = pos_t'(al + $urandom_range(70) - 30);
        bt = pos_t'(at + $urandom_range(70) - 30);
        bw = dim_t'($urandom_range(80, 1));
        bh = dim_t'($urandom_range(80, 1));
        if ($urandom_range(19) == 0) aw = '0;
        if ($urandom_range(19) == 0) bh = '0;
      end else if (kind < 85) begin
        al = pos_t'($urandom);
        at = pos_t'($urandom);
        aw = dim_t'($urandom);
        ah = dim_t'($urandom);
        bl = pos_t'($urandom);
        bt = pos_t'($urandom);
        bw = dim_t'($urandom);
        bh = dim_t'($urandom);
      end else begin
        al = extreme_coord();
        at = extreme_coord();
        aw = extreme_size();
        ah = extreme_size();
        bl = extreme_coord();
        bt = extreme_coord();
        bw = extreme_size();
        bh = extreme_size();
      end
      send_pair(op, al, at, aw, ah, bl, bt, bw, bh);
    end
    in_valid = 1'b0;
    calm     = 1'b0;

    // Drain, then allow a few more cycles for any stray result item.
    while (rects_owed != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (rect_errors == 0 && rects_owed == 0) begin
      $display("tb_rect_set_op_unit: clean");
    end else begin
      $display("tb_rect_set_op_unit: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
